// ----- src/avg_pkg.sv -----
// Shared widths, register indexes and queue status type for the ADC block averager.
package avg_pkg;

  localparam int CNT_W     = 8;
  localparam int DELTA_W   = 24;
  localparam int AVG_W     = 24;
  localparam int DEV_W     = 24;
  localparam int THR_W     = 25;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SAMPLE_COUNT    = 2'd0;
  localparam cfg_idx_t CFG_TARE_MODE       = 2'd1;
  localparam cfg_idx_t CFG_THRESHOLD_DELTA = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/avg_queue.sv -----
// Small register FIFO carrying finished blocks from the accumulator to the divider.
module avg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   data_o,
  output avg_pkg::q_stat_t   stat_o
);
  import avg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- src/avg_front.sv -----
// Sample accumulator: running sum, min and max; emits a job at the end of each block.
module avg_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      raw_word_i,
  input  logic [avg_pkg::CNT_W-1:0]   sample_count_i,
  input  avg_pkg::q_stat_t            q_stat_i,
  output logic                        push_o,
  output logic [SAMPLE_BITS+avg_pkg::CNT_W-1:0] job_sum_o,
  output logic [avg_pkg::CNT_W-1:0]   job_taken_o,
  output logic [avg_pkg::DEV_W-1:0]   job_dev_o
);
  import avg_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  logic [CNT_W-1:0]              idx_q;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d, smp;
  logic signed [SUM_W-1:0]       smp_ext;
  logic [CNT_W-1:0]              count_eff;
  logic [CNT_W:0]                taken;
  logic                          first, done, accept;
  logic [SAMPLE_BITS:0]          dev_full;
  logic [SAMPLE_BITS+DEV_W:0]    dev_ext;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign smp       = signed'(raw_word_i);
  assign smp_ext   = signed'({{CNT_W{raw_word_i[SAMPLE_BITS-1]}}, raw_word_i});
  // a count of zero behaves as one
  assign count_eff = (sample_count_i == '0) ? CNT_W'(1) : sample_count_i;
  assign first     = (idx_q == '0);
  assign taken     = (CNT_W + 1)'(idx_q) + 1'b1;
  assign done      = (taken >= {1'b0, count_eff});

  always_comb begin
    if (first) begin
      sum_d = smp_ext;
      min_d = smp;
      max_d = smp;
    end else begin
      sum_d = sum_q + smp_ext;
      min_d = (smp < min_q) ? smp : min_q;
      max_d = (smp > max_q) ? smp : max_q;
    end
  end

  assign dev_full    = {max_d[SAMPLE_BITS-1], max_d} - {min_d[SAMPLE_BITS-1], min_d};
  assign dev_ext     = {{DEV_W{1'b0}}, dev_full};
  assign push_o      = accept && done;
  assign job_sum_o   = sum_d;
  assign job_taken_o = taken[CNT_W-1:0];
  assign job_dev_o   = dev_ext[DEV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= done ? '0 : taken[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

// ----- src/avg_back.sv -----
// Block finisher: serial restoring divide, tare update, threshold and result register.
module avg_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  avg_pkg::q_stat_t                  q_stat_i,
  output logic                              pop_o,
  input  logic [SAMPLE_BITS+avg_pkg::CNT_W-1:0] job_sum_i,
  input  logic [avg_pkg::CNT_W-1:0]         job_taken_i,
  input  logic [avg_pkg::DEV_W-1:0]         job_dev_i,
  input  logic                              tare_mode_i,
  input  logic signed [avg_pkg::DELTA_W-1:0] threshold_delta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [avg_pkg::AVG_W-1:0]  average_o,
  output logic [avg_pkg::DEV_W-1:0]         deviation_o,
  output logic signed [avg_pkg::THR_W-1:0]  trip_level_o,
  output logic                              was_tare_o
);
  import avg_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int BCW   = $clog2(SUM_W);
  localparam int TW    = SAMPLE_BITS + THR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_NEG  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   neg_q;
  logic [SUM_W-1:0]       mag_q;
  logic [CNT_W-1:0]       rem_q, div_q;
  logic [DEV_W-1:0]       dev_q;
  logic [BCW-1:0]         bit_cnt_q;
  logic signed [SAMPLE_BITS-1:0] tare_q, avg_full, tare_d;
  logic                   out_valid_q, out_free, load_out;

  logic [CNT_W:0]         trial, trial_diff;
  logic                   ge;
  logic [CNT_W-1:0]       rem_d;
  logic [SAMPLE_BITS+AVG_W-1:0] avg_ext;
  logic signed [TW-1:0]   thr_sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign load_out = (state_q == ST_FIN) && out_free;

  // one quotient bit per cycle
  assign trial      = {rem_q, mag_q[SUM_W-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign ge         = (trial >= {1'b0, div_q});
  assign rem_d      = ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];

  assign avg_full = signed'(mag_q[SAMPLE_BITS-1:0]);
  assign tare_d   = tare_mode_i ? avg_full : tare_q;
  assign avg_ext  = {{AVG_W{avg_full[SAMPLE_BITS-1]}}, avg_full};
  assign thr_sum  = signed'({{THR_W{tare_d[SAMPLE_BITS-1]}}, tare_d})
                  + signed'({{(TW-DELTA_W){threshold_delta_i[DELTA_W-1]}}, threshold_delta_i});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_stat_i.empty) state_d = ST_DIV;
      ST_DIV:  if (bit_cnt_q == '0) state_d = ST_NEG;
      ST_NEG:  state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tare_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
        tare_q      <= tare_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          neg_q     <= job_sum_i[SUM_W-1];
          mag_q     <= job_sum_i[SUM_W-1] ? -job_sum_i : job_sum_i;
          rem_q     <= '0;
          div_q     <= job_taken_i;
          dev_q     <= job_dev_i;
          bit_cnt_q <= BCW'(SUM_W - 1);
        end
      end
      ST_DIV: begin
        rem_q     <= rem_d;
        mag_q     <= {mag_q[SUM_W-2:0], ge};
        bit_cnt_q <= bit_cnt_q - 1'b1;
      end
      ST_NEG: begin
        // truncation toward zero: divide the magnitude, then restore the sign
        mag_q <= neg_q ? -mag_q : mag_q;
      end
      ST_FIN: begin
        if (out_free) begin
          average_o    <= signed'(avg_ext[AVG_W-1:0]);
          deviation_o  <= dev_q;
          trip_level_o <= thr_sum[THR_W-1:0];
          was_tare_o   <= tare_mode_i;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/adc_sample_averager_with_tare.sv -----
// Top level of the ADC block averager with min/max deviation and tare offset.
//
//  channel | role   | handshake               | payload
//  --------+--------+-------------------------+-----------------------------------------------
//  in      | sink   | in_valid_i/in_stall_o   | raw_word_i
//  out     | source | out_valid_o/out_stall_i | average_o, deviation_o, trip_level_o, was_tare_o
//  cfg     | sink   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The accumulator takes one sample beat per cycle while in_stall_o is low. Each block's result
// goes through the one-bit-per-cycle restoring divider, a sign fix-up and the result register.
// Up to QUEUE_DEPTH finished blocks wait between accumulator and divider; in_stall_o rises
// only when that queue is full. Reset is asynchronous and needs no clearing pass.
// The result register lets the divider finish the next block while a result is stalled.
module adc_sample_averager_with_tare #(
  parameter int SAMPLE_BITS = 24,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            raw_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [avg_pkg::AVG_W-1:0]  average_o,
  output logic [avg_pkg::DEV_W-1:0]         deviation_o,
  output logic signed [avg_pkg::THR_W-1:0]  trip_level_o,
  output logic                              was_tare_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  avg_pkg::cfg_idx_t                 cfg_index_i,
  input  logic [avg_pkg::DELTA_W-1:0]       cfg_data_i
);
  import avg_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int JOB_W = SUM_W + CNT_W + DEV_W;

  logic [CNT_W-1:0]          sample_count_q;
  logic                      tare_mode_q;
  logic signed [DELTA_W-1:0] threshold_delta_q;

  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [JOB_W-1:0] q_wdata, q_rdata;
  logic [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0] f_taken;
  logic [DEV_W-1:0] f_dev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q    <= CNT_W'(1);
      tare_mode_q       <= 1'b0;
      threshold_delta_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_COUNT:    sample_count_q    <= cfg_data_i[CNT_W-1:0];
        CFG_TARE_MODE:       tare_mode_q       <= cfg_data_i[0];
        CFG_THRESHOLD_DELTA: threshold_delta_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  avg_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_word_i    (raw_word_i),
    .sample_count_i(sample_count_q),
    .q_stat_i      (q_stat),
    .push_o        (q_push),
    .job_sum_o     (f_sum),
    .job_taken_o   (f_taken),
    .job_dev_o     (f_dev)
  );

  assign q_wdata = {f_sum, f_taken, f_dev};

  avg_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_wdata),
    .pop_i (q_pop),
    .data_o(q_rdata),
    .stat_o(q_stat)
  );

  avg_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .job_sum_i        (q_rdata[JOB_W-1 -: SUM_W]),
    .job_taken_i      (q_rdata[DEV_W +: CNT_W]),
    .job_dev_i        (q_rdata[DEV_W-1:0]),
    .tare_mode_i      (tare_mode_q),
    .threshold_delta_i(threshold_delta_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .average_o        (average_o),
    .deviation_o      (deviation_o),
    .trip_level_o     (trip_level_o),
    .was_tare_o       (was_tare_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("block queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("block queue read while empty");

  a_result_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(q_pop))
    else $error("result appeared one cycle after a divide started");
`endif

endmodule

// ----- bench/adc_sample_averager_with_tare_test.sv -----
// Self-checking bench for the ADC block averager: random beats, stalls and register phases.
`timescale 1ns / 1ps

module adc_sample_averager_with_tare_test;
  import avg_pkg::*;

  localparam int SAMPLE_W   = 24;
  localparam int SETTLE_CYC = 60;
  localparam int HOLD_CYC   = 800;
  localparam int RAND_ITEMS = 1250;
  localparam int LIMIT_CYC  = 600_000;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [DEV_W-1:0]        deviation;
    logic signed [THR_W-1:0] trip_level;
    logic                    was_tare;
  } block_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SAMPLE_W-1:0]     raw_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [AVG_W-1:0] average;
  logic [DEV_W-1:0]        deviation;
  logic signed [THR_W-1:0] trip_level;
  logic                    was_tare;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_idx_t                cfg_index = CFG_SAMPLE_COUNT;
  logic [DELTA_W-1:0]      cfg_data = '0;

  adc_sample_averager_with_tare #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .raw_word_i     (raw_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .average_o      (average),
    .deviation_o    (deviation),
    .trip_level_o   (trip_level),
    .was_tare_o     (was_tare),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor copy of the registers and the accumulator
  logic [CNT_W-1:0] cfg_count = 8'd1;
  logic             cfg_tare = 1'b0;
  longint           cfg_delta = 0;
  int unsigned      acc_index = 0;
  longint           acc_sum = 0;
  longint           acc_min = 0;
  longint           acc_max = 0;
  longint           tare_ofs = 0;

  logic [SAMPLE_W-1:0] word_q[$];
  block_result_t       block_expect_q[$];
  int                  fail_cnt = 0;
  int                  idle_pct = 0;
  int                  in_gap_left = 0;
  int                  ostall_left = 0;
  logic                in_acc = 1'b0;
  logic                hold_arm = 1'b0;
  int                  hold_cnt = 0;
  logic                long_hold;
  int                  cycles = 0;

  assign long_hold = hold_arm && (hold_cnt < HOLD_CYC);

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  // Folds one sample into the running block; returns 1 when the block closes.
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] word,
                                     output block_result_t res);
    longint      s, avg, dv, thr;
    int unsigned blk_len, taken;
    s = $signed(word);
    blk_len = (cfg_count == 0) ? 1 : cfg_count;
    res = '0;
    if (acc_index == 0) begin
      acc_sum = s;
      acc_min = s;
      acc_max = s;
    end else begin
      acc_sum += s;
      if (s > acc_max) acc_max = s;
      if (s < acc_min) acc_min = s;
    end
    taken = acc_index + 1;
    if (taken < blk_len) begin
      acc_index = taken;
      return 1'b0;
    end
    // count lowered mid-block: divide by what was actually taken
    acc_index = 0;
    avg = acc_sum / longint'(taken);
    if (cfg_tare) tare_ofs = avg;
    dv = acc_max - acc_min;
    thr = tare_ofs + cfg_delta;
    res.average = avg[AVG_W-1:0];
    res.deviation = dv[DEV_W-1:0];
    res.trip_level = thr[THR_W-1:0];
    res.was_tare = cfg_tare;
    return 1'b1;
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap_left != 0) begin
        in_valid <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (word_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        in_gap_left <= $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b1;
        raw_word <= word_q.pop_front();
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (ostall_left != 0) begin
      out_stall <= 1'b1;
      ostall_left <= ostall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      ostall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long receiver hold-off, so the block backs up and stalls its input
  always @(negedge clk) begin
    if (long_hold) hold_cnt <= hold_cnt + 1;
  end

  // monitor: predicts on each sample beat, checks each result beat
  always @(posedge clk) begin : monitor
    block_result_t exp_r, got_r;
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      if (fold_sample(raw_word, exp_r)) block_expect_q.push_back(exp_r);
    end
    if (rst_n && out_valid && !out_stall) begin
      got_r.average = average;
      got_r.deviation = deviation;
      got_r.trip_level = trip_level;
      got_r.was_tare = was_tare;
      if (block_expect_q.size() == 0) begin
        note_fail($sformatf("unexpected result avg=%0d dev=%0h thr=%0d tare=%0b",
                            got_r.average, got_r.deviation, got_r.trip_level,
                            got_r.was_tare));
      end else begin
        exp_r = block_expect_q.pop_front();
        if (got_r.average !== exp_r.average || got_r.deviation !== exp_r.deviation ||
            got_r.trip_level !== exp_r.trip_level ||
            got_r.was_tare !== exp_r.was_tare) begin
          note_fail($sformatf("mismatch exp avg=%0d dev=%0h thr=%0d tare=%0b",
                              exp_r.average, exp_r.deviation, exp_r.trip_level,
                              exp_r.was_tare));
          if (fail_cnt <= 10)
            $display("         got avg=%0d dev=%0h thr=%0d tare=%0b",
                     got_r.average, got_r.deviation, got_r.trip_level, got_r.was_tare);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [DELTA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SAMPLE_COUNT:    cfg_count = data[CNT_W-1:0];
      CFG_TARE_MODE:       cfg_tare = data[0];
      CFG_THRESHOLD_DELTA: cfg_delta = $signed(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // all samples taken, all results back, divider quiet
  task automatic settle();
    while (word_q.size() != 0 || in_valid || block_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  rand_left, ph_n, pick;
    logic [CNT_W-1:0]    cnt;
    logic [DELTA_W-1:0]  dl;
    logic [SAMPLE_W-1:0] w;
    logic                pressure;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // reset defaults: one sample per block, measure mode
    word_q = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001, 24'h800001};
    settle();

    // zero count behaves as one
    write_reg(CFG_SAMPLE_COUNT, 24'd0);
    word_q = '{24'h123456, 24'hFEDCBA};
    settle();

    // tare blocks: full-scale deviation, truncation toward zero on negative sums
    write_reg(CFG_SAMPLE_COUNT, 24'd4);
    write_reg(CFG_TARE_MODE, 24'd1);
    write_reg(CFG_THRESHOLD_DELTA, 24'h7FFFFF);
    word_q = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE};
    settle();

    // partial block, then count lowered below it; mode and delta taken at block end
    write_reg(CFG_TARE_MODE, 24'd0);
    write_reg(CFG_SAMPLE_COUNT, 24'd8);
    word_q = '{24'h000100, 24'hFFF000, 24'h3A0000};
    settle();
    write_reg(CFG_TARE_MODE, 24'd1);
    write_reg(CFG_THRESHOLD_DELTA, 24'h800000);
    write_reg(CFG_SAMPLE_COUNT, 24'd2);
    word_q = '{24'h000007};
    settle();
    write_reg(CFG_TARE_MODE, 24'd0);
    word_q = '{24'h400000, 24'hC00001};
    settle();

    // largest blocks, sums at both extremes
    idle_pct = 10;
    write_reg(CFG_SAMPLE_COUNT, 24'd255);
    write_reg(CFG_THRESHOLD_DELTA, DELTA_W'($urandom));
    repeat (255) word_q.push_back(24'h7FFFFF);
    repeat (255) word_q.push_back(24'h800000);
    rand_left = RAND_ITEMS - 510;
    settle();

    while (rand_left > 0) begin
      ph_n = $urandom_range(15, 60);
      pressure = !hold_arm && rand_left <= 500;
      if (rand_left <= 200) idle_pct = 0;
      else if ($urandom_range(0, 3) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(5, 40);
      pick = $urandom_range(0, 99);
      if (pick < 45) cnt = CNT_W'($urandom_range(1, 4));
      else if (pick < 80) cnt = CNT_W'($urandom_range(5, 16));
      else if (pick < 95) cnt = CNT_W'($urandom_range(17, 48));
      else cnt = '0;
      if (pressure) begin
        cnt = 8'd1;
        ph_n = 80;
      end
      if (ph_n > rand_left) ph_n = rand_left;
      write_reg(CFG_SAMPLE_COUNT, {16'($urandom), cnt});
      if ($urandom_range(0, 1) == 1) write_reg(CFG_TARE_MODE, DELTA_W'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) dl = 24'h7FFFFF;
        else if (pick == 1) dl = 24'h800000;
        else dl = DELTA_W'($urandom);
        write_reg(CFG_THRESHOLD_DELTA, dl);
      end
      if (pressure) hold_arm = 1'b1;
      repeat (ph_n) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       w = 24'h7FFFFF;
          1:       w = 24'h800000;
          2:       w = SAMPLE_W'($urandom_range(0, 31) - 16);
          default: w = SAMPLE_W'($urandom);
        endcase
        word_q.push_back(w);
      end
      rand_left -= ph_n;
      settle();
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
